>>> src/mlb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Maglev lookup table builder.
// No dependencies; every other file of the block depends on this package.
package mlb_pkg;

   // Field widths of the request and response transfers.
   localparam int ID_W       = 31;
   localparam int IDX_W      = 12;
   localparam int OP_W       = 2;
   localparam int STATUS_W   = 2;

   // Default sizing of the table and of the backend set.
   localparam int DEF_TABLE_SIZE   = 4093;
   localparam int DEF_MAX_BACKENDS = 64;

   // Skip bias of the permutation and width of the dividend fed to the modulo unit.
   localparam int SKIP_BIAS  = 1000;
   localparam int DIVIDEND_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_ADD     = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_REBUILD = 2'd2,
      OP_LOOKUP  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK     = 2'd0,
      STS_FULL   = 2'd1,
      STS_ABSENT = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_INIT_CLR,
      ST_IDLE,
      ST_CLR,
      ST_SCAN,
      ST_APPLY,
      ST_SORT_END,
      ST_MOD,
      ST_ENT_WR,
      ST_FILL_RD,
      ST_FILL_LOAD,
      ST_PROBE,
      ST_CHECK,
      ST_FILL_NEXT,
      ST_LK_RD,
      ST_RESULT,
      ST_RESP
   } state_type;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CLEAR,
      CMD_SCAN,
      CMD_APPLY,
      CMD_SORT_END,
      CMD_MOD_STEP,
      CMD_ENT_WRITE,
      CMD_FILL_RD,
      CMD_FILL_LOAD,
      CMD_PROBE,
      CMD_CHECK,
      CMD_FILL_NEXT,
      CMD_LOOKUP_RD,
      CMD_RESULT
   } cmd_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      cmd_type cmd;
   } dp_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      op_type op;
      logic   clr_last;
      logic   scan_done;
      logic   best_found;
      logic   nrank_zero;
      logic   mod_last;
      logic   ent_exhausted;
      logic   probe_hit;
      logic   cnt_last;
      logic   table_full;
      logic   round_last;
      logic   progress;
   } dp_status_type;

endpackage

>>> src/mlb_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response transfers.
// Depends on mlb_pkg for the field widths.
interface mlb_req_if;
   logic                          valid;
   logic                          ready;
   logic [mlb_pkg::OP_W-1:0]      operation;
   logic [mlb_pkg::ID_W-1:0]      backend_id;
   logic [mlb_pkg::IDX_W-1:0]     table_index;

   modport source (output valid, output operation, output backend_id,
                   output table_index, input ready);
   modport sink   (input valid, input operation, input backend_id,
                   input table_index, output ready);
endinterface

interface mlb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mlb_pkg::ID_W-1:0]      result_backend;
   logic                          hit;
   logic [mlb_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output result_backend, output hit,
                   output status, input ready);
   modport sink   (input valid, input result_backend, input hit,
                   input status, output ready);
endinterface

>>> src/mlb_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the Maglev lookup table builder.
// Depends on mlb_pkg; drives commands into mlb_dpath and reads its status.
module mlb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [mlb_pkg::OP_W-1:0] req_operation,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output mlb_pkg::dp_cmd_type    cmd_o,
   input  mlb_pkg::dp_status_type status_i
);
   import mlb_pkg::*;

   state_type state_ff, state_in;

   // State register; reset starts the table clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd_o.cmd = CMD_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_INIT_CLR: begin
            cmd_o.cmd = CMD_CLEAR;
            if (status_i.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd_o.cmd = CMD_LOAD;
               case (op_type'(req_operation))
                  OP_ADD, OP_REMOVE: state_in = ST_SCAN;
                  OP_REBUILD:        state_in = ST_CLR;
                  default:           state_in = ST_LK_RD;
               endcase
            end
         end
         ST_CLR: begin
            cmd_o.cmd = CMD_CLEAR;
            if (status_i.clr_last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd_o.cmd = CMD_SCAN;
            if (status_i.scan_done) begin
               state_in = (status_i.op == OP_REBUILD) ? ST_SORT_END : ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd_o.cmd = CMD_APPLY;
            state_in  = ST_RESULT;
         end
         ST_SORT_END: begin
            cmd_o.cmd = CMD_SORT_END;
            if (status_i.best_found)      state_in = ST_MOD;
            else if (status_i.nrank_zero) state_in = ST_RESULT;
            else                          state_in = ST_FILL_RD;
         end
         ST_MOD: begin
            cmd_o.cmd = CMD_MOD_STEP;
            if (status_i.mod_last) state_in = ST_ENT_WR;
         end
         ST_ENT_WR: begin
            cmd_o.cmd = CMD_ENT_WRITE;
            state_in  = ST_SCAN;
         end
         ST_FILL_RD: begin
            cmd_o.cmd = CMD_FILL_RD;
            state_in  = ST_FILL_LOAD;
         end
         ST_FILL_LOAD: begin
            cmd_o.cmd = CMD_FILL_LOAD;
            state_in  = status_i.ent_exhausted ? ST_FILL_NEXT : ST_PROBE;
         end
         ST_PROBE: begin
            cmd_o.cmd = CMD_PROBE;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            cmd_o.cmd = CMD_CHECK;
            if (status_i.probe_hit && !status_i.cnt_last) state_in = ST_PROBE;
            else                                          state_in = ST_FILL_NEXT;
         end
         ST_FILL_NEXT: begin
            cmd_o.cmd = CMD_FILL_NEXT;
            if (status_i.table_full || (status_i.round_last && !status_i.progress)) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_FILL_RD;
            end
         end
         ST_LK_RD: begin
            cmd_o.cmd = CMD_LOOKUP_RD;
            state_in  = ST_RESULT;
         end
         ST_RESULT: begin
            cmd_o.cmd = CMD_RESULT;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> src/mlb_dpath.sv
`timescale 1ns / 1ps
// Datapath: backend set, ordered permutation entries, modulo unit and lookup table.
// Depends on mlb_pkg; acts on commands from mlb_ctrl.
module mlb_dpath #(
   parameter int TABLE_SIZE   = mlb_pkg::DEF_TABLE_SIZE,
   parameter int MAX_BACKENDS = mlb_pkg::DEF_MAX_BACKENDS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mlb_pkg::dp_cmd_type         cmd_i,
   output mlb_pkg::dp_status_type      status_o,
   input  logic [mlb_pkg::OP_W-1:0]    req_operation,
   input  logic [mlb_pkg::ID_W-1:0]    req_backend_id,
   input  logic [mlb_pkg::IDX_W-1:0]   req_table_index,
   output logic [mlb_pkg::ID_W-1:0]    rsp_result_backend,
   output logic                        rsp_hit,
   output logic [mlb_pkg::STATUS_W-1:0] rsp_status
);
   import mlb_pkg::*;

   localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int CW = $clog2(TABLE_SIZE + 1);
   localparam int IW = (MAX_BACKENDS > 1) ? $clog2(MAX_BACKENDS) : 1;
   localparam int SW = $clog2(MAX_BACKENDS + 1);
   localparam int PW = 2 * DIVIDEND_W;
   localparam int MOD_STEPS = 3;
   localparam logic [AW:0]   MOD_A  = (AW+1)'(TABLE_SIZE);
   localparam logic [AW:0]   MOD_B  = (AW+1)'(TABLE_SIZE - 1);
   localparam logic [CW-1:0] SIZE_C = CW'(TABLE_SIZE);
   localparam logic [SW-1:0] NSLOT  = SW'(MAX_BACKENDS);
   localparam logic [DIVIDEND_W-1:0] DIV_A = DIVIDEND_W'(TABLE_SIZE);
   localparam logic [DIVIDEND_W-1:0] DIV_B = DIVIDEND_W'(TABLE_SIZE - 1);
   localparam logic [DIVIDEND_W-1:0] RECIP_A =
      DIVIDEND_W'((64'd1 << DIVIDEND_W) / TABLE_SIZE);
   localparam logic [DIVIDEND_W-1:0] RECIP_B =
      DIVIDEND_W'((64'd1 << DIVIDEND_W) / (TABLE_SIZE - 1));

   // Captured request.
   op_type           op_ff;
   logic [ID_W-1:0]  bid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             idx_ok_ff;

   // Backend set.
   logic [ID_W-1:0]         mid_mem [MAX_BACKENDS];
   logic [MAX_BACKENDS-1:0] mvalid_ff;
   logic [SW-1:0]           scan_ff;
   logic [ID_W-1:0]         mid_rd_ff;
   logic [IW-1:0]           rd_slot_ff;
   logic                    rd_v_ff;
   logic                    match_ff, free_ff;
   logic [IW-1:0]           match_slot_ff, free_slot_ff;

   // Selection sort over the set.
   logic            best_found_ff, have_last_ff;
   logic [ID_W-1:0] best_ff, last_ff;
   logic [SW-1:0]   nrank_ff;

   // Reciprocal modulo unit for both divisors: product, remainder estimate, correction.
   logic [DIVIDEND_W-1:0] xa_ff, xb_ff, ma, mb;
   logic [PW-1:0]         pa_ff, pb_ff;
   logic [AW:0]           da_ff, db_ff;
   logic [AW-1:0]         ra_ff, rb_ff, ra_in, rb_in;
   logic [1:0]            mstep_ff;

   // Permutation entries in ascending id order.
   logic [ID_W-1:0] ent_id_mem   [MAX_BACKENDS];
   logic [AW-1:0]   ent_pos_mem  [MAX_BACKENDS];
   logic [AW-1:0]   ent_skip_mem [MAX_BACKENDS];
   logic [CW-1:0]   ent_cnt_mem  [MAX_BACKENDS];
   logic [ID_W-1:0] ent_id_rd_ff;
   logic [AW-1:0]   ent_pos_rd_ff, ent_skip_rd_ff;
   logic [CW-1:0]   ent_cnt_rd_ff;

   // Fill walk.
   logic [ID_W-1:0] cur_id_ff;
   logic [AW-1:0]   cur_pos_ff, cur_skip_ff, pos_in;
   logic [AW:0]     pos_sum;
   logic [CW-1:0]   cur_cnt_ff, cnt_in, filled_ff;
   logic [IW-1:0]   k_ff;
   logic            progress_ff;

   // Lookup table: valid bit over the backend id.
   logic [ID_W:0]   tbl_mem [TABLE_SIZE];
   logic [ID_W:0]   tbl_rd_ff;
   logic [AW-1:0]   tbl_raddr;
   logic [AW-1:0]   clr_ff;

   // Response registers.
   logic [ID_W-1:0] res_ff;
   logic            hit_ff, hit_in;
   status_type      status_ff;

   // The quotient estimate is at most one low, so the remainder estimate is below twice
   // the divisor and one compare and subtract finishes it.
   always_comb begin
      ma    = xa_ff - pa_ff[PW-1:DIVIDEND_W] * DIV_A;
      mb    = xb_ff - pb_ff[PW-1:DIVIDEND_W] * DIV_B;
      ra_in = (da_ff >= MOD_A) ? AW'(da_ff - MOD_A) : AW'(da_ff);
      rb_in = (db_ff >= MOD_B) ? AW'(db_ff - MOD_B) : AW'(db_ff);
   end

   // Next permutation position and cursor count.
   always_comb begin
      pos_sum = {1'b0, cur_pos_ff} + {1'b0, cur_skip_ff};
      pos_in  = (pos_sum >= MOD_A) ? AW'(pos_sum - MOD_A) : AW'(pos_sum);
      cnt_in  = cur_cnt_ff + CW'(1);
   end

   assign tbl_raddr = (cmd_i.cmd == CMD_PROBE) ? cur_pos_ff : AW'(32'(idx_ff));
   assign hit_in    = (op_ff == OP_LOOKUP) && idx_ok_ff && tbl_rd_ff[ID_W];

   // Lookup table memory: clear and claim writes, probe and lookup reads.
   always_ff @(posedge clock) begin
      if (cmd_i.cmd == CMD_CLEAR) begin
         tbl_mem[clr_ff] <= '0;
      end else if (cmd_i.cmd == CMD_CHECK && !tbl_rd_ff[ID_W]) begin
         tbl_mem[cur_pos_ff] <= {1'b1, cur_id_ff};
      end
      if (cmd_i.cmd == CMD_PROBE || cmd_i.cmd == CMD_LOOKUP_RD) begin
         tbl_rd_ff <= tbl_mem[tbl_raddr];
      end
   end

   // Member id memory: written on add, read during a scan.
   always_ff @(posedge clock) begin
      if (cmd_i.cmd == CMD_APPLY && op_ff == OP_ADD && !match_ff && free_ff) begin
         mid_mem[free_slot_ff] <= bid_ff;
      end
      if (cmd_i.cmd == CMD_SCAN && scan_ff < NSLOT) begin
         mid_rd_ff <= mid_mem[scan_ff[IW-1:0]];
      end
   end

   // Permutation entry memory: written when ranked and after each probe.
   always_ff @(posedge clock) begin
      if (cmd_i.cmd == CMD_ENT_WRITE) begin
         ent_id_mem[nrank_ff[IW-1:0]]   <= last_ff;
         ent_pos_mem[nrank_ff[IW-1:0]]  <= ra_ff;
         ent_skip_mem[nrank_ff[IW-1:0]] <= rb_ff + AW'(1);
         ent_cnt_mem[nrank_ff[IW-1:0]]  <= '0;
      end else if (cmd_i.cmd == CMD_CHECK) begin
         ent_id_mem[k_ff]   <= cur_id_ff;
         ent_pos_mem[k_ff]  <= pos_in;
         ent_skip_mem[k_ff] <= cur_skip_ff;
         ent_cnt_mem[k_ff]  <= cnt_in;
      end
      if (cmd_i.cmd == CMD_FILL_RD) begin
         ent_id_rd_ff   <= ent_id_mem[k_ff];
         ent_pos_rd_ff  <= ent_pos_mem[k_ff];
         ent_skip_rd_ff <= ent_skip_mem[k_ff];
         ent_cnt_rd_ff  <= ent_cnt_mem[k_ff];
      end
   end

   // Control state: clear address and member valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff    <= '0;
         mvalid_ff <= '0;
      end else begin
         case (cmd_i.cmd)
            CMD_LOAD:  clr_ff <= '0;
            CMD_CLEAR: clr_ff <= clr_ff + AW'(1);
            CMD_APPLY: begin
               if (op_ff == OP_ADD && !match_ff && free_ff) begin
                  mvalid_ff[free_slot_ff] <= 1'b1;
               end else if (op_ff == OP_REMOVE && match_ff) begin
                  mvalid_ff[match_slot_ff] <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // Working registers of the scan, sort, modulo and fill steps.
   always_ff @(posedge clock) begin
      case (cmd_i.cmd)
         CMD_LOAD: begin
            op_ff         <= op_type'(req_operation);
            bid_ff        <= req_backend_id;
            idx_ff        <= req_table_index;
            idx_ok_ff     <= 32'(req_table_index) < 32'(TABLE_SIZE);
            scan_ff       <= '0;
            rd_v_ff       <= 1'b0;
            match_ff      <= 1'b0;
            free_ff       <= 1'b0;
            best_found_ff <= 1'b0;
            have_last_ff  <= 1'b0;
            nrank_ff      <= '0;
            status_ff     <= STS_OK;
         end
         CMD_SCAN: begin
            if (scan_ff < NSLOT) begin
               scan_ff    <= scan_ff + SW'(1);
               rd_slot_ff <= scan_ff[IW-1:0];
               rd_v_ff    <= 1'b1;
            end else begin
               rd_v_ff    <= 1'b0;
            end
            // Check the slot read in the previous cycle.
            if (rd_v_ff) begin
               if (mvalid_ff[rd_slot_ff]) begin
                  if (mid_rd_ff == bid_ff) begin
                     match_ff      <= 1'b1;
                     match_slot_ff <= rd_slot_ff;
                  end
                  if ((!have_last_ff || mid_rd_ff > last_ff) &&
                      (!best_found_ff || mid_rd_ff < best_ff)) begin
                     best_found_ff <= 1'b1;
                     best_ff       <= mid_rd_ff;
                  end
               end else if (!free_ff) begin
                  free_ff      <= 1'b1;
                  free_slot_ff <= rd_slot_ff;
               end
            end
         end
         CMD_APPLY: begin
            if (op_ff == OP_ADD && !match_ff && !free_ff) begin
               status_ff <= STS_FULL;
            end else if (op_ff == OP_REMOVE && !match_ff) begin
               status_ff <= STS_ABSENT;
            end
         end
         CMD_SORT_END: begin
            if (best_found_ff) begin
               last_ff      <= best_ff;
               have_last_ff <= 1'b1;
               xa_ff        <= DIVIDEND_W'(best_ff);
               xb_ff        <= DIVIDEND_W'(best_ff) + DIVIDEND_W'(SKIP_BIAS);
               mstep_ff     <= '0;
            end else begin
               k_ff         <= '0;
               filled_ff    <= '0;
               progress_ff  <= 1'b0;
            end
         end
         CMD_MOD_STEP: begin
            // All three stages advance each cycle: product, remainder estimate, then the corrected remainders.
            pa_ff    <= PW'(xa_ff) * PW'(RECIP_A);
            pb_ff    <= PW'(xb_ff) * PW'(RECIP_B);
            da_ff    <= (AW+1)'(ma);
            db_ff    <= (AW+1)'(mb);
            ra_ff    <= ra_in;
            rb_ff    <= rb_in;
            mstep_ff <= mstep_ff + 2'd1;
         end
         CMD_ENT_WRITE: begin
            nrank_ff      <= nrank_ff + SW'(1);
            scan_ff       <= '0;
            rd_v_ff       <= 1'b0;
            best_found_ff <= 1'b0;
         end
         CMD_FILL_LOAD: begin
            cur_id_ff   <= ent_id_rd_ff;
            cur_pos_ff  <= ent_pos_rd_ff;
            cur_skip_ff <= ent_skip_rd_ff;
            cur_cnt_ff  <= ent_cnt_rd_ff;
         end
         CMD_CHECK: begin
            cur_pos_ff <= pos_in;
            cur_cnt_ff <= cnt_in;
            // A free slot is claimed by the current backend.
            if (!tbl_rd_ff[ID_W]) begin
               filled_ff   <= filled_ff + CW'(1);
               progress_ff <= 1'b1;
            end
         end
         CMD_FILL_NEXT: begin
            if (status_o.round_last) begin
               k_ff        <= '0;
               progress_ff <= 1'b0;
            end else begin
               k_ff <= k_ff + IW'(1);
            end
         end
         CMD_RESULT: begin
            hit_ff <= hit_in;
            res_ff <= hit_in ? tbl_rd_ff[ID_W-1:0] : '0;
         end
         default: ;
      endcase
   end

   // Status toward the controller.
   always_comb begin
      status_o.op            = op_ff;
      status_o.clr_last      = (clr_ff == AW'(TABLE_SIZE - 1));
      status_o.scan_done     = (scan_ff == NSLOT);
      status_o.best_found    = best_found_ff;
      status_o.nrank_zero    = (nrank_ff == '0);
      status_o.mod_last      = (mstep_ff == 2'(MOD_STEPS - 1));
      status_o.ent_exhausted = (ent_cnt_rd_ff == SIZE_C);
      status_o.probe_hit     = tbl_rd_ff[ID_W];
      status_o.cnt_last      = (cnt_in == SIZE_C);
      status_o.table_full    = (filled_ff == SIZE_C);
      status_o.round_last    = ((SW'(k_ff) + SW'(1)) == nrank_ff);
      status_o.progress      = progress_ff;
   end

   assign rsp_result_backend = res_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_status         = status_ff;

endmodule

>>> src/maglev_lookup_table_builder_top.sv
`timescale 1ns / 1ps
// Lookup: the response follows the request transfer after a table read and then a result step.
// Add and remove: one slot read per cycle over the backend set, then the update and the result.
// Rebuild: a table clear, a scan per backend to rank it and run the modulo unit, then the fill
// walk with a probe and a check per table probe plus a read, load and next step per backend turn.
// One request is in flight at a time; the next is taken after the response transfer.
// Reset: synchronous; a clearing pass over the table runs before the first request is taken.
module maglev_lookup_table_builder_top #(
   parameter int TABLE_SIZE   = mlb_pkg::DEF_TABLE_SIZE,
   parameter int MAX_BACKENDS = mlb_pkg::DEF_MAX_BACKENDS
) (
   input logic         clock,
   input logic         reset,
   mlb_req_if.sink     req_ch,
   mlb_rsp_if.source   rsp_ch
);
   import mlb_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_sts;

   // Sequencing of each operation.
   mlb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_operation (req_ch.operation),
      .req_ready     (req_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_ready     (rsp_ch.ready),
      .cmd_o         (dp_cmd),
      .status_i      (dp_sts)
   );

   // Storage and arithmetic.
   mlb_dpath #(
      .TABLE_SIZE   (TABLE_SIZE),
      .MAX_BACKENDS (MAX_BACKENDS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd_i              (dp_cmd),
      .status_o           (dp_sts),
      .req_operation      (req_ch.operation),
      .req_backend_id     (req_ch.backend_id),
      .req_table_index    (req_ch.table_index),
      .rsp_result_backend (rsp_ch.result_backend),
      .rsp_hit            (rsp_ch.hit),
      .rsp_status         (rsp_ch.status)
   );

endmodule

>>> src/mlb_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the Maglev lookup table builder, bound to the top level.
// Depends on mlb_pkg for the status codes.
module mlb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mlb_pkg::ID_W-1:0]      rsp_result_backend,
   input logic                          rsp_hit,
   input logic [mlb_pkg::STATUS_W-1:0]  rsp_status
);
   import mlb_pkg::*;

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_result_backend) && $stable(rsp_hit) && $stable(rsp_status)))
      else $error("response changed while stalled");

   // A hit only comes from a lookup, whose status is always ok.
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_status == STS_OK))
      else $error("hit with non-ok status");

   // A miss carries a zero backend id.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_result_backend == '0))
      else $error("miss with nonzero backend");

   // No request is taken while a response is still pending.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> !rsp_valid)
      else $error("request taken with response pending");

   // No response right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind maglev_lookup_table_builder_top mlb_checker u_mlb_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_result_backend (rsp_ch.result_backend),
   .rsp_hit            (rsp_ch.hit),
   .rsp_status         (rsp_ch.status)
);
